FILE: hdl/hprt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hprt_pkg: shared types and codes
// Operation and result codes, field widths and the cell control group.
// ----------------------------------------------------------------------------
package hprt_pkg;

    localparam int TAG_W     = 16;
    localparam int SLOT_W    = 4;
    localparam int SLOT_SPAN = 16;
    localparam int MAX_OUT   = 32;
    localparam int NOUT_W    = 6;

    localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_SET     = 2'd2;
    localparam logic [1:0] FUNC_RETIRE  = 2'd3;

    localparam logic [1:0] KIND_GRANT   = 2'd0;
    localparam logic [1:0] KIND_RECLAIM = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_FULL    = 2'd3;

    typedef struct packed {
        logic shift;
        logic load;
        logic tail;
    } t_cell_ctl;

endpackage
`default_nettype wire

FILE: hdl/hazard_pointer_reclaim_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hazard_pointer_reclaim_table: hazard-pointer registry
// Guard slot table plus a chain of retired record cells swept in order.
// ----------------------------------------------------------------------------
// acquire, retire and plain set guard answer in the cycle after the request
// release and zero set guard on a usable slot sweep the record chain,
//   one cell per cycle while the output is not stalled
// one request at a time; the next request is taken once the sweep finishes
// synchronous active-low reset clears slots, record count and control state
module hazard_pointer_reclaim_table #(
    parameter int SLOT_COUNT    = 16,
    parameter int RETIRED_DEPTH = 32,
    parameter int ADDR_BITS     = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [1:0]                    i_func,
    input  wire [hprt_pkg::SLOT_W-1:0]   i_slot,
    input  wire [31:0]                   i_address,
    input  wire [hprt_pkg::TAG_W-1:0]    i_tag,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [1:0]                   o_kind,
    output logic [hprt_pkg::SLOT_W-1:0]  o_granted_slot,
    output logic [hprt_pkg::TAG_W-1:0]   o_reclaim_tag,
    output logic                         o_last
);
    import hprt_pkg::*;

    localparam int USABLE = (SLOT_COUNT < SLOT_SPAN) ? SLOT_COUNT : SLOT_SPAN;
    localparam int CW     = $clog2(RETIRED_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SWEEP  = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [SLOT_COUNT-1:0] r_act;
    logic [ADDR_BITS-1:0]  r_guard [SLOT_COUNT];
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_left, n_left;
    logic [NOUT_W-1:0]     r_nout, n_nout;
    logic                  r_pend, n_pend;
    logic [TAG_W-1:0]      r_pend_tag, n_pend_tag;

    logic                  r_ov, n_ov;
    logic [1:0]            r_kind, n_kind;
    logic [SLOT_W-1:0]     r_gslot, n_gslot;
    logic [TAG_W-1:0]      r_rtag, n_rtag;
    logic                  r_last, n_last;

    logic [ADDR_BITS-1:0]  in_addr;
    logic [ADDR_BITS-1:0]  chk_addr;
    logic                  hit, guarded;
    logic [SLOT_COUNT-1:0] sel;
    logic                  sel_any;
    logic                  free_any;
    logic [SLOT_W-1:0]     free_idx;
    logic                  out_free, accept, step;
    logic                  take_head;

    logic [ADDR_BITS-1:0]  c_addr [RETIRED_DEPTH];
    logic [TAG_W-1:0]      c_tag  [RETIRED_DEPTH];
    t_cell_ctl             c_ctl  [RETIRED_DEPTH];

    generate
        if (ADDR_BITS > 32) begin : g_wide
            assign in_addr = {{(ADDR_BITS - 32){1'b0}}, i_address};
        end else if (ADDR_BITS == 32) begin : g_even
            assign in_addr = i_address;
        end else begin : g_narrow
            assign in_addr = i_address[ADDR_BITS-1:0];
        end
    endgenerate

    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_state == ST_IDLE) && out_free;
    assign accept   = i_valid && o_ready;
    assign step     = (r_state == ST_SWEEP) && (r_left != '0) && out_free;

    // slot decode and lowest free slot
    always_comb begin
        sel      = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int k = USABLE - 1; k >= 0; k--) begin
            sel[k] = (i_slot == SLOT_W'(k));
            if (!r_act[k]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(k);
            end
        end
    end
    assign sel_any = |sel;

    // one compare bank shared by retire and the sweep head
    assign chk_addr = (r_state == ST_SWEEP) ? c_addr[0] : in_addr;
    always_comb begin
        hit = 1'b0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            hit = hit | (r_act[k] && (r_guard[k] == chk_addr));
        end
    end
    assign guarded   = hit && (chk_addr != '0);
    assign take_head = !guarded && (r_nout < NOUT_W'(MAX_OUT));

    // record chain
    genvar gi;
    generate
        for (gi = 0; gi < RETIRED_DEPTH; gi++) begin : g_cell
            assign c_ctl[gi].load  = accept && (i_func == FUNC_RETIRE) && guarded
                                     && (r_count == CW'(gi));
            assign c_ctl[gi].shift = step;
            assign c_ctl[gi].tail  = !take_head && (CW'(gi) == CW'(r_count - CW'(1)));
            hprt_cell #(
                .ADDR_BITS(ADDR_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (c_ctl[gi]),
                .i_new_addr  (in_addr),
                .i_new_tag   (i_tag),
                .i_right_addr(c_addr[(gi + 1) % RETIRED_DEPTH]),
                .i_right_tag (c_tag[(gi + 1) % RETIRED_DEPTH]),
                .i_head_addr (c_addr[0]),
                .i_head_tag  (c_tag[0]),
                .o_addr      (c_addr[gi]),
                .o_tag       (c_tag[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_left     = r_left;
        n_nout     = r_nout;
        n_pend     = r_pend;
        n_pend_tag = r_pend_tag;
        n_ov       = r_ov && !i_ready;
        n_kind     = r_kind;
        n_gslot    = r_gslot;
        n_rtag     = r_rtag;
        n_last     = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_ov    = 1'b1;
                    n_kind  = KIND_DONE;
                    n_gslot = '0;
                    n_rtag  = '0;
                    n_last  = 1'b1;
                    unique case (i_func)
                        FUNC_ACQUIRE: begin
                            n_kind  = free_any ? KIND_GRANT : KIND_FULL;
                            n_gslot = free_any ? free_idx : '0;
                        end
                        FUNC_RELEASE, FUNC_SET: begin
                            if (sel_any && ((i_func == FUNC_RELEASE) || (in_addr == '0))) begin
                                n_ov    = 1'b0;
                                n_state = ST_SWEEP;
                                n_left  = r_count;
                                n_nout  = '0;
                                n_pend  = 1'b0;
                            end
                        end
                        FUNC_RETIRE: begin
                            if (!guarded) begin
                                n_kind = KIND_RECLAIM;
                                n_rtag = i_tag;
                            end else if (r_count >= CW'(RETIRED_DEPTH)) begin
                                n_kind = KIND_FULL;
                            end else begin
                                n_count = CW'(r_count + CW'(1));
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SWEEP: begin
                if (r_left == '0) begin
                    n_state = ST_FINISH;
                end else if (step) begin
                    n_left = CW'(r_left - CW'(1));
                    if (take_head) begin
                        n_count    = CW'(r_count - CW'(1));
                        n_nout     = NOUT_W'(r_nout + NOUT_W'(1));
                        n_pend     = 1'b1;
                        n_pend_tag = c_tag[0];
                        // previous reclaim is known not to be the last one
                        if (r_pend) begin
                            n_ov    = 1'b1;
                            n_kind  = KIND_RECLAIM;
                            n_gslot = '0;
                            n_rtag  = r_pend_tag;
                            n_last  = 1'b0;
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_kind  = r_pend ? KIND_RECLAIM : KIND_DONE;
                    n_gslot = '0;
                    n_rtag  = r_pend ? r_pend_tag : '0;
                    n_last  = 1'b1;
                    n_pend  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_nout  <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
            r_act   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_nout  <= n_nout;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
            if (accept && (i_func == FUNC_ACQUIRE) && free_any) begin
                r_act[free_idx] <= 1'b1;
            end
            if (accept && (i_func == FUNC_RELEASE)) begin
                r_act <= r_act & ~sel;
            end
        end
        r_pend_tag <= n_pend_tag;
        r_kind     <= n_kind;
        r_gslot    <= n_gslot;
        r_rtag     <= n_rtag;
        r_last     <= n_last;
    end

    // guard table, cleared with the slots at reset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SLOT_COUNT; k++) begin
            if (!i_rst_n) begin
                r_guard[k] <= '0;
            end else if (accept && (i_func == FUNC_ACQUIRE) && free_any
                         && (free_idx == SLOT_W'(k))) begin
                r_guard[k] <= '0;
            end else if (accept && sel[k] && (i_func == FUNC_RELEASE)) begin
                r_guard[k] <= '0;
            end else if (accept && sel[k] && (i_func == FUNC_SET)) begin
                r_guard[k] <= in_addr;
            end
        end
    end

    assign o_valid        = r_ov;
    assign o_kind         = r_kind;
    assign o_granted_slot = r_gslot;
    assign o_reclaim_tag  = r_rtag;
    assign o_last         = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RETIRED_DEPTH))
        else $error("record count beyond store depth");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_kind == KIND_GRANT) || (o_kind == KIND_FULL)) |-> o_last)
        else $error("grant or full result without last");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("request taken during sweep");

    a_sweep_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (r_left <= r_count))
        else $error("sweep walks beyond stored records");

endmodule
`default_nettype wire

FILE: hdl/hprt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hprt_cell: one retired record cell
// Holds one record; loads a new record, takes its right neighbor's record
// on a shift, or takes the head record when it is the tail of the queue.
// ----------------------------------------------------------------------------
module hprt_cell #(
    parameter int ADDR_BITS = 32
) (
    input  wire                        i_clk,
    input  hprt_pkg::t_cell_ctl        i_ctl,
    input  wire [ADDR_BITS-1:0]        i_new_addr,
    input  wire [hprt_pkg::TAG_W-1:0]  i_new_tag,
    input  wire [ADDR_BITS-1:0]        i_right_addr,
    input  wire [hprt_pkg::TAG_W-1:0]  i_right_tag,
    input  wire [ADDR_BITS-1:0]        i_head_addr,
    input  wire [hprt_pkg::TAG_W-1:0]  i_head_tag,
    output logic [ADDR_BITS-1:0]       o_addr,
    output logic [hprt_pkg::TAG_W-1:0] o_tag
);
    import hprt_pkg::*;

    logic [ADDR_BITS-1:0] r_addr;
    logic [TAG_W-1:0]     r_tag;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_addr <= i_new_addr;
            r_tag  <= i_new_tag;
        end else if (i_ctl.shift) begin
            // kept head record rejoins at the tail of the queue
            r_addr <= i_ctl.tail ? i_head_addr : i_right_addr;
            r_tag  <= i_ctl.tail ? i_head_tag : i_right_tag;
        end
    end

    assign o_addr = r_addr;
    assign o_tag  = r_tag;

endmodule
`default_nettype wire
